// ===== rtl/nmf_pkg.sv =====
`timescale 1ns / 1ps
package nmf_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int MaxDepth   = 256;
    localparam int SampleBits = 16;

    localparam int DimBits   = 9;
    localparam int CfgIdxBits = 2;
    localparam int PosBits   = $clog2(MaxWidth * MaxHeight * MaxDepth + 1);
    localparam int PlaneBits = $clog2(MaxWidth * MaxHeight + 1);
    localparam int HistSize  = 2 * MaxWidth * MaxHeight + 4 * MaxWidth;
    localparam int HistBits  = $clog2(HistSize);
    localparam int SumBits   = SampleBits + 5;
    localparam int NumBits   = SumBits;
    localparam int CntBits   = 5;

    localparam logic [CfgIdxBits-1:0] RegWidth  = 2'd0;
    localparam logic [CfgIdxBits-1:0] RegHeight = 2'd1;
    localparam logic [CfgIdxBits-1:0] RegDepth  = 2'd2;

    localparam logic CmdSample = 1'b0;
    localparam logic CmdFlush  = 1'b1;

    typedef enum logic [3:0] {
        ST_SETUP0, ST_SETUP1, ST_IDLE, ST_CHECK, ST_NB_ADDR, ST_NB_READ,
        ST_NB_ACC, ST_DIV_LOAD, ST_DIV, ST_DONE
    } t_state;

    typedef struct packed {
        logic setup0;
        logic setup1;
        logic take;
        logic nb_start;
        logic nb_addr;
        logic nb_acc;
        logic div_load;
        logic div_step;
        logic load_out;
    } t_ctl;

    typedef struct packed {
        logic emit;
        logic nb_last;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/nmf_in_if.sv =====
`timescale 1ns / 1ps
interface nmf_in_if;
    import nmf_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [SampleBits-1:0] sample;
    modport source (output valid, command, sample, input ready);
    modport sink   (input valid, command, sample, output ready);
endinterface

// ===== rtl/nmf_out_if.sv =====
`timescale 1ns / 1ps
interface nmf_out_if;
    import nmf_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [SampleBits-1:0] mean;
    logic [CntBits-1:0]           count;
    logic                         last;
    modport source (output valid, mean, count, last, input ready);
    modport sink   (input valid, mean, count, last, output ready);
endinterface

// ===== rtl/neighbourhood_mean_filter_unit.sv =====
`timescale 1ns / 1ps
// Box mean filter over a streamed sample array (3x3 for depth 1, 3x3x3 otherwise).
// Samples arrive in raster order on i_in; each result on o_out is the mean of
// the valid neighbours of the next position, rounded to nearest with ties away
// from zero, with the neighbour count and a last flag. Results lag the input by
// W*H+W+1 positions in 3D and W+1 in 2D; send flush items to drain that lag.
// An item that causes no result is accepted and checked. An item that causes
// a result is accepted and checked, its 27 neighbours are read one at a time
// from the single history memory (address, read and accumulate states each),
// the divider is loaded, a 21-step bit-serial divider runs, and the result is
// handed off when the output register is free. No new item is accepted until
// the last one is through. A stalled receiver holds the hand-off, and input,
// for as long as the output register stays full. A register write restarts
// the array and holds off input while the setup states recompute the plane
// size, array size and lag. Write registers only while the block is idle.
module neighbourhood_mean_filter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nmf_pkg::CfgIdxBits-1:0]  i_cfg_index,
    input  logic [nmf_pkg::DimBits-1:0]     i_cfg_data,
    nmf_in_if.sink                          i_in,
    nmf_out_if.source                       o_out
);
    import nmf_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // sequencer: setup, accept, neighbour walk, divide, hand off to the output register
    nmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // config registers, history memory, position counters, accumulator, divider, output register
    nmf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_command   (i_in.command),
        .i_sample    (i_in.sample),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_mean      (o_out.mean),
        .o_count     (o_out.count),
        .o_last      (o_out.last)
    );

endmodule

// ===== rtl/nmf_ctrl.sv =====
`timescale 1ns / 1ps
module nmf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  nmf_pkg::t_sts i_sts,
    output nmf_pkg::t_ctl o_ctl
);
    import nmf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SETUP0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_SETUP0: begin
                o_ctl.setup0 = 1'b1;
                n_state = ST_SETUP1;
            end
            ST_SETUP1: begin
                o_ctl.setup1 = 1'b1;
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.take = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.emit) begin
                    o_ctl.nb_start = 1'b1;
                    n_state = ST_NB_ADDR;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_NB_ADDR: begin
                o_ctl.nb_addr = 1'b1;
                n_state = ST_NB_READ;
            end
            ST_NB_READ: n_state = ST_NB_ACC;
            ST_NB_ACC: begin
                o_ctl.nb_acc = 1'b1;
                n_state = i_sts.nb_last ? ST_DIV_LOAD : ST_NB_ADDR;
            end
            ST_DIV_LOAD: begin
                o_ctl.div_load = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_SETUP0;
        endcase
        // a register write restarts the array and recomputes the geometry
        if (i_cfg_we) begin
            n_state    = ST_SETUP0;
            o_in_ready = 1'b0;
            o_ctl      = '0;
        end
    end

endmodule

// ===== rtl/nmf_dpath.sv =====
`timescale 1ns / 1ps
module nmf_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nmf_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input  logic [nmf_pkg::DimBits-1:0]        i_cfg_data,
    input  nmf_pkg::t_ctl                      i_ctl,
    output nmf_pkg::t_sts                      o_sts,
    input  logic                               i_command,
    input  logic signed [nmf_pkg::SampleBits-1:0] i_sample,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [nmf_pkg::SampleBits-1:0] o_mean,
    output logic [nmf_pkg::CntBits-1:0]        o_count,
    output logic                               o_last
);
    import nmf_pkg::*;

    localparam logic [DimBits-1:0]  MaxW = DimBits'(MaxWidth);
    localparam logic [DimBits-1:0]  MaxH = DimBits'(MaxHeight);
    localparam logic [DimBits-1:0]  MaxD = DimBits'(MaxDepth);
    localparam logic [HistBits-1:0] HistLast = HistBits'(HistSize - 1);
    localparam int AddrBits = HistBits + 2;

    logic [DimBits-1:0]   r_wraw, r_hraw, r_draw;
    logic [DimBits-1:0]   r_w, r_h, r_d;
    logic [PlaneBits-1:0] r_plane;
    logic [PosBits-1:0]   r_n, r_lag;
    logic [PosBits-1:0]   r_ip, r_op;
    logic [HistBits-1:0]  r_iaddr, r_oaddr;
    logic [DimBits-1:0]   r_ox, r_oy, r_oz;
    logic [1:0]           r_dx, r_dy, r_dz;
    logic [HistBits-1:0]  r_naddr;
    logic                 r_nvalid, r_rvalid;
    logic signed [SampleBits-1:0] r_rd;
    logic signed [SumBits-1:0]    r_sum;
    logic [CntBits-1:0]   r_cnt;
    logic [NumBits-1:0]   r_num;
    logic [CntBits+1:0]   r_rem;
    logic [CntBits-1:0]   r_dstep;
    logic                 r_neg, r_last, r_emit_last;
    logic                 r_ovalid;
    logic signed [SampleBits-1:0] r_mean;
    logic [CntBits-1:0]   r_ocount;
    logic                 r_olast;

    logic signed [SampleBits-1:0] mem [HistSize];

    function automatic logic [DimBits-1:0] clamp(input logic [DimBits-1:0] v,
                                                 input logic [DimBits-1:0] mx);
        if (v == '0) return DimBits'(1);
        if (v > mx) return mx;
        return v;
    endfunction

    // config registers and derived geometry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wraw <= DimBits'(256);
            r_hraw <= DimBits'(256);
            r_draw <= DimBits'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegWidth:  r_wraw <= i_cfg_data;
                RegHeight: r_hraw <= i_cfg_data;
                RegDepth:  r_draw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.setup0) begin
            r_w     <= clamp(r_wraw, MaxW);
            r_h     <= clamp(r_hraw, MaxH);
            r_d     <= clamp(r_draw, MaxD);
            r_plane <= PlaneBits'(clamp(r_wraw, MaxW) * clamp(r_hraw, MaxH));
        end
        if (i_ctl.setup1) begin
            r_n   <= PosBits'(r_plane * r_d);
            r_lag <= (r_d > DimBits'(1))
                   ? PosBits'(r_plane) + PosBits'(r_w) + PosBits'(1)
                   : PosBits'(r_w) + PosBits'(1);
        end
    end

    // emission rule
    logic [PosBits:0] need_raw;
    logic [PosBits-1:0] need;
    always_comb begin
        need_raw = {1'b0, r_op} + {1'b0, r_lag} + (PosBits+1)'(1);
        need = (need_raw > {1'b0, r_n}) ? r_n : need_raw[PosBits-1:0];
    end
    assign o_sts.emit = (r_op < r_n) && (r_ip >= need);

    // input side: restart and sample write
    logic restart, do_write;
    assign restart  = i_ctl.take && (i_command == CmdSample) && (r_ip == r_n)
                   && (r_op == r_n);
    assign do_write = i_ctl.take && (i_command == CmdSample) && (restart || (r_ip < r_n));

    logic [HistBits-1:0] waddr;
    assign waddr = restart ? '0 : r_iaddr;

    always_ff @(posedge i_clk) begin
        if (do_write) mem[waddr] <= i_sample;
        r_rd <= mem[r_naddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_ip    <= '0;
            r_iaddr <= '0;
            r_op    <= '0;
            r_oaddr <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_oz    <= '0;
        end else begin
            if (restart) begin
                r_op    <= '0;
                r_oaddr <= '0;
                r_ox    <= '0;
                r_oy    <= '0;
                r_oz    <= '0;
            end
            if (do_write) begin
                r_ip    <= (restart ? '0 : r_ip) + PosBits'(1);
                r_iaddr <= (waddr == HistLast) ? '0 : waddr + HistBits'(1);
            end
            if (i_ctl.load_out) begin
                r_op    <= r_op + PosBits'(1);
                r_oaddr <= (r_oaddr == HistLast) ? '0 : r_oaddr + HistBits'(1);
                if (r_ox == r_w - DimBits'(1)) begin
                    r_ox <= '0;
                    if (r_oy == r_h - DimBits'(1)) begin
                        r_oy <= '0;
                        r_oz <= r_oz + DimBits'(1);
                    end else begin
                        r_oy <= r_oy + DimBits'(1);
                    end
                end else begin
                    r_ox <= r_ox + DimBits'(1);
                end
            end
        end
    end

    // neighbour walk
    logic nvalid;
    logic signed [AddrBits-1:0] off, addr;
    always_comb begin
        nvalid = !((r_dx == 2'd0) && (r_ox == '0))
              && !((r_dx == 2'd2) && (r_ox == r_w - DimBits'(1)))
              && !((r_dy == 2'd0) && (r_oy == '0))
              && !((r_dy == 2'd2) && (r_oy == r_h - DimBits'(1)))
              && !((r_dz == 2'd0) && (r_oz == '0))
              && !((r_dz == 2'd2) && (r_oz == r_d - DimBits'(1)));
        off = AddrBits'(signed'({1'b0, r_dx})) - AddrBits'(1);
        case (r_dy)
            2'd0: off = off - AddrBits'(r_w);
            2'd2: off = off + AddrBits'(r_w);
            default: ;
        endcase
        case (r_dz)
            2'd0: off = off - AddrBits'(r_plane);
            2'd2: off = off + AddrBits'(r_plane);
            default: ;
        endcase
        addr = AddrBits'(r_oaddr) + off;
        if (addr < 0) addr = addr + AddrBits'(HistSize);
        else if (addr >= AddrBits'(HistSize)) addr = addr - AddrBits'(HistSize);
    end

    assign o_sts.nb_last = (r_dx == 2'd2) && (r_dy == 2'd2) && (r_dz == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_ctl.nb_start) begin
            r_dx        <= '0;
            r_dy        <= '0;
            r_dz        <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_emit_last <= (r_op + PosBits'(1) == r_n);
        end
        if (i_ctl.nb_addr) begin
            r_naddr  <= addr[HistBits-1:0];
            r_nvalid <= nvalid;
        end
        r_rvalid <= r_nvalid;
        if (i_ctl.nb_acc) begin
            if (r_rvalid) begin
                r_sum <= r_sum + SumBits'(r_rd);
                r_cnt <= r_cnt + CntBits'(1);
            end
            if (r_dx == 2'd2) begin
                r_dx <= '0;
                if (r_dy == 2'd2) begin
                    r_dy <= '0;
                    r_dz <= r_dz + 2'd1;
                end else begin
                    r_dy <= r_dy + 2'd1;
                end
            end else begin
                r_dx <= r_dx + 2'd1;
            end
        end
    end

    // restoring division of (2|sum| + cnt) by 2cnt
    logic [CntBits+1:0] trial, den;
    assign den   = {1'b0, r_cnt, 1'b0};
    assign trial = {r_rem[CntBits:0], r_num[NumBits-1]};
    assign o_sts.div_done = (r_dstep == CntBits'(NumBits - 1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_load) begin
            r_neg   <= r_sum[SumBits-1];
            r_num   <= NumBits'({(r_sum[SumBits-1] ? -r_sum : r_sum), 1'b0})
                     + NumBits'(r_cnt);
            r_rem   <= '0;
            r_dstep <= '0;
            r_last  <= r_emit_last;
        end
        if (i_ctl.div_step) begin
            r_dstep <= r_dstep + CntBits'(1);
            if (trial >= den) begin
                r_rem <= trial - den;
                r_num <= {r_num[NumBits-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_num <= {r_num[NumBits-2:0], 1'b0};
            end
        end
    end

    // output register
    assign o_sts.out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_mean   <= r_neg ? -signed'(r_num[SampleBits-1:0])
                              : signed'(r_num[SampleBits-1:0]);
            r_ocount <= r_cnt;
            r_olast  <= r_last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_mean  = r_mean;
    assign o_count = r_ocount;
    assign o_last  = r_olast;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import nmf_pkg::*;

    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned ItemGoal   = 1100;
    localparam int unsigned SettleCycles = 150;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxBits-1:0] i_cfg_index;
    logic [DimBits-1:0] i_cfg_data;

    nmf_in_if  in_ch ();
    nmf_out_if out_ch ();

    neighbourhood_mean_filter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    typedef struct packed {
        logic signed [SampleBits-1:0] mean;
        logic [CntBits-1:0]           count;
        logic                         last;
    } t_mean_result;

    // One row of the directed table. The group selects the array shape the
    // row runs under; rows with a typed result carry it in the same row.
    typedef struct packed {
        logic [1:0]                   grp;
        logic                         cmd;
        logic signed [SampleBits-1:0] smp;
        logic                         typed;
        logic signed [SampleBits-1:0] mean;
        logic [CntBits-1:0]           count;
        logic                         last;
    } t_dir_row;

    localparam int NumRows = 20;
    localparam t_dir_row DirRows [NumRows] = '{
        // group 0: registers written as 0, so the array is 1x1x1
        '{2'd0, CmdSample, 16'sh7fff, 1'b1, 16'sh7fff, 5'd1, 1'b1},
        '{2'd0, CmdSample, 16'sh8000, 1'b1, 16'sh8000, 5'd1, 1'b1},
        '{2'd0, CmdSample, 16'sh0000, 1'b1, 16'sh0000, 5'd1, 1'b1},
        '{2'd0, CmdSample, 16'shffff, 1'b1, 16'shffff, 5'd1, 1'b1},
        '{2'd0, CmdFlush,  16'sh1234, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd0, CmdSample, 16'sh0001, 1'b1, 16'sh0001, 5'd1, 1'b1},
        // group 1: 2x1x1, ties round away from zero
        '{2'd1, CmdSample, 16'sh0001, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd1, CmdSample, 16'sh0002, 1'b1, 16'sh0002, 5'd2, 1'b0},
        '{2'd1, CmdFlush,  16'sh0000, 1'b1, 16'sh0002, 5'd2, 1'b1},
        '{2'd1, CmdSample, 16'shffff, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd1, CmdSample, 16'shfffe, 1'b1, 16'shfffe, 5'd2, 1'b0},
        '{2'd1, CmdFlush,  16'sh0000, 1'b1, 16'shfffe, 5'd2, 1'b1},
        '{2'd1, CmdFlush,  16'sh0000, 1'b0, 16'sh0,    5'd0, 1'b0},
        // group 2: 3x2x2 volume, early flush, then drain by predictor
        '{2'd2, CmdSample, 16'sh7fff, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd2, CmdFlush,  16'sh0000, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd2, CmdSample, 16'sh8000, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd2, CmdSample, 16'sh5555, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd2, CmdSample, 16'shaaaa, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd2, CmdSample, 16'sh7fff, 1'b0, 16'sh0,    5'd0, 1'b0},
        '{2'd2, CmdSample, 16'sh8000, 1'b0, 16'sh0,    5'd0, 1'b0}
    };

    // Predictor state: raw register values, sample history and positions.
    logic [DimBits-1:0] reg_w, reg_h, reg_d;
    logic signed [SampleBits-1:0] sample_hist [HistSize];
    int unsigned in_pos, out_pos;

    t_mean_result pending_means [$];
    int unsigned items_sent;
    int unsigned means_seen;
    int unsigned num_errors;
    int unsigned arrays_run;
    int unsigned cycle_count = 0;

    function automatic int unsigned clamp_dim(input logic [DimBits-1:0] v,
                                              input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic int unsigned array_size();
        return clamp_dim(reg_w, MaxWidth) * clamp_dim(reg_h, MaxHeight) *
               clamp_dim(reg_d, MaxDepth);
    endfunction

    // Mean of the valid neighbours of position pos.
    function automatic t_mean_result box_mean(input int unsigned pos);
        int unsigned w, h, d, plane, n, cnt, q;
        int x, y, z, xx, yy, zz;
        longint sum;
        longint unsigned mag;
        t_mean_result r;
        w = clamp_dim(reg_w, MaxWidth);
        h = clamp_dim(reg_h, MaxHeight);
        d = clamp_dim(reg_d, MaxDepth);
        plane = w * h;
        n = plane * d;
        x = pos % w;
        y = (pos / w) % h;
        z = pos / plane;
        sum = 0;
        cnt = 0;
        for (int dz = -1; dz <= 1; dz++) begin
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    zz = z + dz;
                    yy = y + dy;
                    xx = x + dx;
                    if (zz >= 0 && zz < int'(d) && yy >= 0 && yy < int'(h) &&
                        xx >= 0 && xx < int'(w)) begin
                        sum += sample_hist[(zz * plane + yy * w + xx) % HistSize];
                        cnt++;
                    end
                end
            end
        end
        mag = (sum < 0) ? -sum : sum;
        q = 32'((2 * mag + cnt) / (2 * cnt));
        r.mean  = SampleBits'((sum < 0) ? -q : q);
        r.count = CntBits'(cnt);
        r.last  = (pos + 1 == n);
        return r;
    endfunction

    // Advance the predictor by one accepted item; return 1 with a result.
    function automatic bit predict_mean(input logic cmd, input logic signed [SampleBits-1:0] smp,
                                        output t_mean_result r);
        int unsigned w, n, lag, need;
        w = clamp_dim(reg_w, MaxWidth);
        n = array_size();
        lag = (clamp_dim(reg_d, MaxDepth) > 1) ?
              w * clamp_dim(reg_h, MaxHeight) + w + 1 : w + 1;
        r = '0;
        if (in_pos > n) in_pos = n;
        if (out_pos > n) out_pos = n;
        if (cmd == CmdSample) begin
            if (in_pos == n && out_pos == n) begin
                in_pos = 0;
                out_pos = 0;
            end
            if (in_pos < n) begin
                sample_hist[in_pos % HistSize] = smp;
                in_pos++;
            end
        end
        if (out_pos >= n) return 0;
        need = out_pos + lag + 1;
        if (need > n) need = n;
        if (in_pos < need) return 0;
        r = box_mean(out_pos);
        out_pos++;
        return 1;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort the run if something hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_mean_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            means_seen++;
            if (pending_means.size() == 0) begin
                $error("result with no expectation: mean %0d count %0d last %0d",
                       out_ch.mean, out_ch.count, out_ch.last);
                num_errors++;
            end else begin
                want = pending_means.pop_front();
                if (out_ch.mean !== want.mean) begin
                    $error("mean: expected %0d, got %0d", want.mean, out_ch.mean);
                    num_errors++;
                end
                if (out_ch.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, out_ch.count);
                    num_errors++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_ch.last);
                    num_errors++;
                end
            end
        end
    end

    // Receiver: stall about 30% of the time, except in a quiet window, and
    // hold off for one long stretch so the block backs up into its input.
    initial begin
        int unsigned hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && means_seen >= 60) begin
                hold_done = 1;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (cycle_count > 20000 && cycle_count < 45000) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Send one item; the predictor advances at the transfer edge.
    task automatic send_item(input logic cmd, input logic signed [SampleBits-1:0] smp,
                             input bit typed, input t_mean_result typed_mean);
        t_mean_result r;
        bit got;
        // drop valid for a random gap, outside the no-gap stretch
        if (!(items_sent >= 600 && items_sent < 800)) begin
            while ($urandom_range(0, 99) < 30) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.sample  <= smp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        got = predict_mean(cmd, smp, r);
        if (got) pending_means.push_back(typed ? typed_mean : r);
    endtask

    // Wait for every expected result, let the block settle, then reconfigure.
    task automatic set_shape(input logic [DimBits-1:0] w, input logic [DimBits-1:0] h,
                             input logic [DimBits-1:0] d);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= RegWidth;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= RegHeight;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_index <= RegDepth;
        i_cfg_data  <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_w = w;
        reg_h = h;
        reg_d = d;
        in_pos = 0;
        out_pos = 0;
        arrays_run++;
    endtask

    function automatic logic signed [SampleBits-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return SampleBits'($urandom);
        endcase
    endfunction

    // One whole array with random content, some noise flushes, then a drain
    // where a sample now and then stands in for a flush.
    task automatic run_array(input logic [DimBits-1:0] w, input logic [DimBits-1:0] h,
                             input logic [DimBits-1:0] d);
        int unsigned n;
        set_shape(w, h, d);
        n = array_size();
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 8) send_item(CmdFlush, SampleBits'($urandom), 0, '0);
            send_item(CmdSample, rand_sample(), 0, '0);
        end
        while (out_pos < n) begin
            if ($urandom_range(0, 99) < 20) send_item(CmdSample, rand_sample(), 0, '0);
            else send_item(CmdFlush, SampleBits'($urandom), 0, '0);
        end
        repeat ($urandom_range(0, 2)) send_item(CmdFlush, SampleBits'($urandom), 0, '0);
    endtask

    initial begin
        t_mean_result tm;
        logic [1:0] cur_grp;
        logic [DimBits-1:0] rw, rh, rd;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = RegWidth;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CmdFlush;
        in_ch.sample = '0;
        reg_w = 9'd256;
        reg_h = 9'd256;
        reg_d = 9'd1;
        in_pos = 0;
        out_pos = 0;
        items_sent = 0;
        means_seen = 0;
        num_errors = 0;
        arrays_run = 0;
        for (int i = 0; i < HistSize; i++) sample_hist[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        cur_grp = 2'd3;
        for (int i = 0; i < NumRows; i++) begin
            if (DirRows[i].grp != cur_grp) begin
                cur_grp = DirRows[i].grp;
                case (cur_grp)
                    2'd0: set_shape(9'd0, 9'd0, 9'd0);
                    2'd1: set_shape(9'd2, 9'd1, 9'd1);
                    default: set_shape(9'd3, 9'd2, 9'd2);
                endcase
            end
            tm = '{DirRows[i].mean, DirRows[i].count, DirRows[i].last};
            send_item(DirRows[i].cmd, DirRows[i].smp, DirRows[i].typed, tm);
        end
        // finish the volume of the last group
        for (int i = 0; i < 6; i++) send_item(CmdSample, rand_sample(), 0, '0);
        while (out_pos < array_size()) send_item(CmdFlush, '0, 0, '0);

        // Extremes of the registers: oversize width, zero height, big depth.
        run_array(9'd511, 9'd1, 9'd0);
        run_array(9'd1, 9'd0, 9'd511);
        run_array(9'd2, 9'd2, 9'd2);

        // Random shapes, mostly small.
        while (items_sent < ItemGoal) begin
            rw = DimBits'($urandom_range(1, 8));
            rh = DimBits'($urandom_range(1, 6));
            rd = ($urandom_range(0, 1) == 0) ? 9'd1 : 9'($urandom_range(2, 4));
            if ($urandom_range(0, 9) == 0) rw = $urandom_range(0, 1) ? 9'd0 : 9'd1;
            run_array(rw, rh, rd);
        end

        in_ch.valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        $display("covered %0d items over %0d array shapes, %0d results checked",
                 items_sent, arrays_run, means_seen);
        if (num_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nmf_pkg.sv
rtl/nmf_in_if.sv
rtl/nmf_out_if.sv
rtl/nmf_ctrl.sv
rtl/nmf_dpath.sv
rtl/neighbourhood_mean_filter_unit.sv
test/tb_top.sv
